@@ rtl/core/tsp_pkg.sv @@
// Time string parser package: transaction types, token codes, status codes
// and the microsecond constants. No dependencies.
package tsp_pkg;

	// Fixed widths of the transaction fields
	localparam int TOTAL_BITS  = 52;
	localparam int STATUS_BITS = 3;

	// Fraction digits kept; later digits are dropped (range 1..6)
	localparam int FRAC_DIGITS = 6;
	localparam int FRAC_IDX_W  = 3;
	localparam int FRAC_US_W   = 20;
	localparam int WEIGHT_W    = 17;

	// Token queue between the classifier and the parser
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

	// Microseconds per field unit
	localparam logic [31:0] US_PER_HOUR = 32'd3600000000;
	localparam logic [31:0] US_PER_MIN  = 32'd60000000;
	localparam logic [31:0] US_PER_SEC  = 32'd1000000;

	typedef logic [STATUS_BITS-1:0] status_t;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_COLONS     = 3'd1;
	localparam status_t ST_COLON_FRAC = 3'd2;
	localparam status_t ST_DEC_TWICE  = 3'd3;
	localparam status_t ST_BAD_CHAR   = 3'd4;

	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_COLON,
		TK_POINT,
		TK_SPACE,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [3:0]  digit;
		logic        is_last;
	} token_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] total_us;
		status_t               status;
	} out_item_t;

	// Weight in microseconds of the fraction digit at position idx
	function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FRAC_IDX_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		case (idx)
			3'd0:    w = 17'd100000;
			3'd1:    w = 17'd10000;
			3'd2:    w = 17'd1000;
			3'd3:    w = 17'd100;
			3'd4:    w = 17'd10;
			3'd5:    w = 17'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/time_string_parser_top.sv @@
// Time string parser, top level. Depends on tsp_pkg, tsp_front, tsp_queue,
// tsp_back and tsp_combine.
// Throughput: one character per cycle while the queue has room, set by the
// parser taking one queued token per cycle unless a last token waits for the
// combiner. A result goes via queue, multiply, pair sum, final sum into output.
// Reset (arst_n low) empties the queue and pipeline and clears the parser.
module time_string_parser_top #(
	parameter int FIELD_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsp_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsp_pkg::out_item_t  out_data
);
	import tsp_pkg::*;

	logic                  q_push, q_full, q_pop, q_valid;
	token_t                q_token, q_head;
	logic                  cmb_valid, cmb_ready;
	logic [FIELD_BITS-1:0] cmb_hours, cmb_minutes, cmb_seconds;
	logic [FRAC_US_W-1:0]  cmb_frac;
	status_t               cmb_status;

	tsp_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_token  (q_token)
	);

	tsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_token),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_head)
	);

	tsp_back #(
		.FIELD_BITS (FIELD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (q_valid),
		.tok         (q_head),
		.tok_pop     (q_pop),
		.cmb_ready   (cmb_ready),
		.cmb_valid   (cmb_valid),
		.cmb_hours   (cmb_hours),
		.cmb_minutes (cmb_minutes),
		.cmb_seconds (cmb_seconds),
		.cmb_frac    (cmb_frac),
		.cmb_status  (cmb_status)
	);

	tsp_combine #(
		.FIELD_BITS (FIELD_BITS)
	) u_combine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (cmb_valid),
		.req_ready   (cmb_ready),
		.req_hours   (cmb_hours),
		.req_minutes (cmb_minutes),
		.req_seconds (cmb_seconds),
		.req_frac    (cmb_frac),
		.req_status  (cmb_status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

@@ rtl/core/tsp_front.sv @@
// Front end: accepts input transactions and classifies each character
// into a token for the queue. Depends on tsp_pkg.
module tsp_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  tsp_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              q_push,
	output tsp_pkg::token_t   q_token
);
	import tsp_pkg::*;

	// Take a transaction whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Character classification
	always_comb begin
		q_token.digit   = in_data.char_code[3:0];
		q_token.is_last = in_data.is_last;
		case (in_data.char_code) inside
			[8'h30:8'h39]:          q_token.kind = TK_DIGIT;
			8'h3A:                  q_token.kind = TK_COLON;
			8'h2E, 8'h2C:           q_token.kind = TK_POINT;
			[8'h09:8'h0D], 8'h20:   q_token.kind = TK_SPACE;
			default:                q_token.kind = TK_OTHER;
		endcase
	end

endmodule

@@ rtl/core/tsp_queue.sv @@
// Token queue: short FIFO that decouples the classifier from the parser.
// Depends on tsp_pkg.
module tsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tsp_pkg::token_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output tsp_pkg::token_t data
);
	import tsp_pkg::*;

	token_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [QUEUE_IDX_W:0]   count_q;

	assign full  = (count_q == (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign data  = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ rtl/core/tsp_back.sv @@
// Back end: walks the token stream, holds the field and fraction state and
// hands the finished fields to the combiner on the last token. Depends on tsp_pkg.
module tsp_back #(
	parameter int FIELD_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tok_valid,
	input  tsp_pkg::token_t                tok,
	output logic                           tok_pop,
	input  logic                           cmb_ready,
	output logic                           cmb_valid,
	output logic [FIELD_BITS-1:0]          cmb_hours,
	output logic [FIELD_BITS-1:0]          cmb_minutes,
	output logic [FIELD_BITS-1:0]          cmb_seconds,
	output logic [tsp_pkg::FRAC_US_W-1:0]  cmb_frac,
	output tsp_pkg::status_t               cmb_status
);
	import tsp_pkg::*;

	logic [FIELD_BITS-1:0] cur_q, min_q, hrs_q;
	logic [FRAC_US_W-1:0]  frac_q;
	logic [FRAC_IDX_W-1:0] frac_idx_q;
	logic [1:0]            colons_q;
	logic                  after_pt_q;
	status_t               err_q;
	logic                  content_q;
	logic                  trail_q;

	logic [FIELD_BITS-1:0] cur_d, min_d, hrs_d;
	logic [FRAC_US_W-1:0]  frac_d;
	logic [FRAC_IDX_W-1:0] frac_idx_d;
	logic [1:0]            colons_d;
	logic                  after_pt_d;
	status_t               err_d;
	logic                  content_d;
	logic                  trail_d;

	logic [FIELD_BITS+3:0] cur_x10;
	logic [WEIGHT_W+3:0]   frac_add;

	// A last token waits for the combiner; others go straight through
	assign tok_pop   = tok_valid && (!tok.is_last || cmb_ready);
	assign cmb_valid = tok_valid && tok.is_last;

	assign cur_x10  = ((FIELD_BITS+4)'(cur_q) << 3) + ((FIELD_BITS+4)'(cur_q) << 1)
	                + (FIELD_BITS+4)'(tok.digit);
	assign frac_add = (WEIGHT_W+4)'(tok.digit) * (WEIGHT_W+4)'(frac_weight(frac_idx_q));

	// Parse one token
	always_comb begin
		cur_d      = cur_q;
		min_d      = min_q;
		hrs_d      = hrs_q;
		frac_d     = frac_q;
		frac_idx_d = frac_idx_q;
		colons_d   = colons_q;
		after_pt_d = after_pt_q;
		err_d      = err_q;
		content_d  = content_q;
		trail_d    = trail_q;
		if (err_q != ST_OK) begin
			// first error wins
		end else if (tok.kind == TK_SPACE) begin
			if (content_q)
				trail_d = 1'b1;
		end else if (trail_q) begin
			err_d = ST_BAD_CHAR;
		end else begin
			content_d = 1'b1;
			case (tok.kind)
				TK_DIGIT: begin
					if (after_pt_q) begin
						if (frac_idx_q < FRAC_IDX_W'(FRAC_DIGITS)) begin
							frac_d     = frac_q + FRAC_US_W'(frac_add);
							frac_idx_d = frac_idx_q + 1'b1;
						end
					end else if (cur_x10[FIELD_BITS+3:FIELD_BITS] != 4'd0) begin
						cur_d = '1;
					end else begin
						cur_d = cur_x10[FIELD_BITS-1:0];
					end
				end
				TK_COLON: begin
					if (colons_q >= 2'd2) begin
						err_d = ST_COLONS;
					end else if (after_pt_q) begin
						err_d = ST_COLON_FRAC;
					end else begin
						colons_d = colons_q + 1'b1;
						hrs_d    = min_q;
						min_d    = cur_q;
						cur_d    = '0;
					end
				end
				TK_POINT: begin
					if (after_pt_q)
						err_d = ST_DEC_TWICE;
					else
						after_pt_d = 1'b1;
				end
				default: err_d = ST_BAD_CHAR;
			endcase
		end
	end

	assign cmb_hours   = hrs_d;
	assign cmb_minutes = min_d;
	assign cmb_seconds = cur_d;
	assign cmb_frac    = frac_d;
	assign cmb_status  = err_d;

	// Parser state; cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			min_q      <= '0;
			hrs_q      <= '0;
			frac_q     <= '0;
			frac_idx_q <= '0;
			colons_q   <= '0;
			after_pt_q <= 1'b0;
			err_q      <= ST_OK;
			content_q  <= 1'b0;
			trail_q    <= 1'b0;
		end else if (tok_pop) begin
			if (tok.is_last) begin
				cur_q      <= '0;
				min_q      <= '0;
				hrs_q      <= '0;
				frac_q     <= '0;
				frac_idx_q <= '0;
				colons_q   <= '0;
				after_pt_q <= 1'b0;
				err_q      <= ST_OK;
				content_q  <= 1'b0;
				trail_q    <= 1'b0;
			end else begin
				cur_q      <= cur_d;
				min_q      <= min_d;
				hrs_q      <= hrs_d;
				frac_q     <= frac_d;
				frac_idx_q <= frac_idx_d;
				colons_q   <= colons_d;
				after_pt_q <= after_pt_d;
				err_q      <= err_d;
				content_q  <= content_d;
				trail_q    <= trail_d;
			end
		end
	end

endmodule

@@ rtl/core/tsp_combine.sv @@
// Combiner: scales the fields to microseconds, sums and saturates them (zero on an
// error status) in a three-stage pipeline ending in the output register. Depends on tsp_pkg.
module tsp_combine #(
	parameter int FIELD_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [FIELD_BITS-1:0]          req_hours,
	input  logic [FIELD_BITS-1:0]          req_minutes,
	input  logic [FIELD_BITS-1:0]          req_seconds,
	input  logic [tsp_pkg::FRAC_US_W-1:0]  req_frac,
	input  tsp_pkg::status_t               req_status,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tsp_pkg::out_item_t             out_data
);
	import tsp_pkg::*;

	localparam int SUM_W = (FIELD_BITS + 34 > TOTAL_BITS + 1) ? FIELD_BITS + 34 : TOTAL_BITS + 1;

	logic                 s1_valid_q, s2_valid_q, out_valid_q;
	logic [SUM_W-1:0]     ph_s1, pm_s1, ps_s1;
	logic [FRAC_US_W-1:0] frac_s1;
	status_t              status_s1, status_s2;
	logic [SUM_W-1:0]     hm_s2, sf_s2;
	logic [SUM_W-1:0]     total;
	out_item_t            out_q;
	logic                 out_load, s2_load, s1_load;

	// Stall chain from the output back to the request side
	assign out_load  = !out_valid_q || out_ready;
	assign s2_load   = !s2_valid_q || out_load;
	assign s1_load   = !s1_valid_q || s2_load;
	assign req_ready = s1_load;

	assign total = hm_s2 + sf_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load)
				s1_valid_q <= req_valid;
			if (s2_load)
				s2_valid_q <= s1_valid_q;
			if (out_load)
				out_valid_q <= s2_valid_q;
		end
	end

	// Stage 1: constant multiplies; stage 2: pair sums; stage 3: final sum
	always_ff @(posedge clk) begin
		if (s1_load) begin
			ph_s1     <= SUM_W'(req_hours) * SUM_W'(US_PER_HOUR);
			pm_s1     <= SUM_W'(req_minutes) * SUM_W'(US_PER_MIN);
			ps_s1     <= SUM_W'(req_seconds) * SUM_W'(US_PER_SEC);
			frac_s1   <= req_frac;
			status_s1 <= req_status;
		end
		if (s2_load) begin
			hm_s2     <= ph_s1 + pm_s1;
			sf_s2     <= ps_s1 + SUM_W'(frac_s1);
			status_s2 <= status_s1;
		end
		if (out_load) begin
			out_q.status <= status_s2;
			if (status_s2 != ST_OK)
				out_q.total_us <= '0;
			else if (total[SUM_W-1:TOTAL_BITS] != '0)
				out_q.total_us <= '1;
			else
				out_q.total_us <= total[TOTAL_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
